FILE: design/dds_pwm_pkg.sv
// ============================================================================
// dds_pwm_pkg
// Shared types and constants of the PWM duty oscillator: field widths, table
// geometry, request codes, register indexes and the duty scaling constants.
// ============================================================================
package dds_pwm_pkg;

    // Waveform table geometry (power of two depth, 1024 entries).
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Field widths.
    localparam int PHASE_W = 32;
    localparam int TIME_W  = 32;
    localparam int VOL_W   = 17;
    localparam int WAVE_W  = 11;
    localparam int TIDX_W  = 10;
    localparam int DUTY_W  = 10;
    localparam int CFG_W   = 8;
    localparam int OCT_W   = 3;

    // Phase split: table index on top, 16 fraction bits below it.
    localparam int FRAC_W   = 16;
    localparam int FRAC_LSB = PHASE_W - IDX_W - FRAC_W;
    localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

    // Datapath widths.
    localparam int PROD_W   = WAVE_W + FRAC_W + 1;
    localparam int MV_W     = VOL_W + WAVE_W;
    localparam int SCALED_W = MV_W + 10;
    localparam int M_W      = SCALED_W - FRAC_W;
    localparam int DIV_SH   = 12;
    localparam int QE_W     = M_W - DIV_SH;
    localparam int REM_W    = DIV_SH + 1;

    // Duty scaling: duty = 400 + floor(800 * vol * val / (65536 * 4095)).
    localparam logic [DUTY_W-1:0] DUTY_MID  = 10'd400;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 10'd799;
    localparam logic [DUTY_W-1:0] DUTY_OFF  = 10'd0;
    localparam logic [REM_W-1:0]  WAVE_FULL = 13'd4095;
    // Any scaled value at or above 399 * 4095 ends at the saturated duty.
    localparam logic [M_W-1:0]    SAT_LIMIT = M_W'(399 * 4095);

    // Octave levels; level two is the unshifted tuning word.
    localparam logic [OCT_W-1:0] OCT_DOWN2 = 3'd0;
    localparam logic [OCT_W-1:0] OCT_DOWN1 = 3'd1;
    localparam logic [OCT_W-1:0] OCT_ZERO  = 3'd2;
    localparam logic [OCT_W-1:0] OCT_UP1   = 3'd3;
    localparam logic [OCT_W-1:0] OCT_UP2   = 3'd4;
    localparam int OCT_STEP = 3;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic CFG_IDX_UPDATE   = 1'b0;
    localparam logic CFG_IDX_DEBOUNCE = 1'b1;
    localparam logic [CFG_W-1:0] UPDATE_RESET   = 8'd50;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 8'd5;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_UP    = 2'd1,
        REQ_DOWN  = 2'd2,
        REQ_WRITE = 2'd3
    } req_type_t;

endpackage

FILE: design/dds_pwm_if.sv
// ============================================================================
// dds_pwm request and result channels
// Valid/ready channels: one carries requests into the oscillator, the other
// carries duty results out of it.
// ============================================================================
interface dds_pwm_req_if;
    logic                            valid;
    logic                            ready;
    dds_pwm_pkg::req_type_t          req_type;
    logic [dds_pwm_pkg::PHASE_W-1:0] base_tuning;
    logic [dds_pwm_pkg::VOL_W-1:0]   volume;
    logic [dds_pwm_pkg::TIME_W-1:0]  time_ms;
    logic [dds_pwm_pkg::TIDX_W-1:0]  table_index;
    logic [dds_pwm_pkg::WAVE_W-1:0]  table_data;

    modport source (
        output valid, req_type, base_tuning, volume, time_ms, table_index, table_data,
        input  ready
    );
    modport sink (
        input  valid, req_type, base_tuning, volume, time_ms, table_index, table_data,
        output ready
    );
endinterface

interface dds_pwm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [dds_pwm_pkg::DUTY_W-1:0] duty;

    modport source (
        output valid, duty,
        input  ready
    );
    modport sink (
        input  valid, duty,
        output ready
    );
endinterface

FILE: design/dds_oscillator_pwm_duty_unit.sv
// ============================================================================
// dds_oscillator_pwm_duty_unit
// Numerically controlled audio oscillator with a linearly interpolated
// waveform table, producing one PWM duty value per sample tick.
// ============================================================================
// The block takes one request at a time. A sounding sample tick, once
// accepted, passes the phase add, the two-port table read, and the
// interpolation, volume scaling and divide-by-constant states before its duty
// enters the output register, held while the previous duty is uncollected.
// A silent tick skips to the output state; an octave press or a table write
// is done at acceptance. The result register frees the request side, so a new
// request is taken while the previous duty waits to be collected. The
// waveform table holds no reset value and needs no clearing pass: every entry
// that a tick reads must have been written first. Configuration writes go
// through the APB port at any time and take effect on the next request.
module dds_oscillator_pwm_duty_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    dds_pwm_req_if.sink                         req,
    dds_pwm_rsp_if.source                       rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dds_pwm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dds_pwm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dds_pwm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PHASE = 9'b000000010,
        S_READ  = 9'b000000100,
        S_MULA  = 9'b000001000,
        S_MULC  = 9'b000010000,
        S_VOL   = 9'b000100000,
        S_SCALE = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    // Control state.
    state_t                               state_reg, state_next;
    logic [dds_pwm_pkg::CFG_W-1:0]        update_interval_reg, debounce_ms_reg;
    logic [dds_pwm_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    logic [dds_pwm_pkg::PHASE_W-1:0]      step_word_reg, step_word_next;
    logic                                 silent_pitch_reg, silent_pitch_next;
    logic [dds_pwm_pkg::VOL_W-1:0]        held_volume_reg, held_volume_next;
    logic [dds_pwm_pkg::CFG_W-1:0]        tick_count_reg, tick_count_next;
    logic                                 first_tick_reg, first_tick_next;
    logic [dds_pwm_pkg::OCT_W-1:0]        octave_level_reg, octave_level_next;
    logic [dds_pwm_pkg::TIME_W-1:0]       last_up_ms_reg, last_up_ms_next;
    logic [dds_pwm_pkg::TIME_W-1:0]       last_down_ms_reg, last_down_ms_next;
    logic                                 rsp_valid_reg, rsp_valid_next;
    logic [dds_pwm_pkg::DUTY_W-1:0]       duty_reg, duty_next;

    // Datapath registers.
    logic [dds_pwm_pkg::WAVE_W-1:0]       rd_a_reg, rd_c_reg;
    logic [dds_pwm_pkg::PROD_W-1:0]       prod_a_reg, prod_a_next;
    logic [dds_pwm_pkg::WAVE_W-1:0]       val_reg, val_next;
    logic [dds_pwm_pkg::MV_W-1:0]         mv_reg, mv_next;
    logic [dds_pwm_pkg::M_W-1:0]          m_reg, m_next;
    logic [dds_pwm_pkg::DUTY_W-1:0]       res_reg, res_next;

    // Waveform table.
    logic [dds_pwm_pkg::WAVE_W-1:0]       wave_mem [dds_pwm_pkg::TABLE_DEPTH];

    logic                                 req_fire;
    logic                                 cfg_write;
    logic                                 tbl_write;
    logic [dds_pwm_pkg::IDX_W-1:0]        wr_idx;
    logic [dds_pwm_pkg::IDX_W-1:0]        rd_idx_a, rd_idx_c;
    logic [dds_pwm_pkg::FRAC_W-1:0]       frac;
    logic [dds_pwm_pkg::FRAC_W:0]         weight_a;
    logic [dds_pwm_pkg::PROD_W-1:0]       interp_sum;
    logic [dds_pwm_pkg::SCALED_W-1:0]     scaled;
    logic [dds_pwm_pkg::QE_W-1:0]         q_est;
    logic [dds_pwm_pkg::REM_W-1:0]        q_rem;
    logic [dds_pwm_pkg::QE_W-1:0]         q_fix;
    logic [dds_pwm_pkg::CFG_W-1:0]        tick_inc;
    logic                                 latch;
    logic [dds_pwm_pkg::PHASE_W-1:0]      octave_word;
    logic [dds_pwm_pkg::TIME_W-1:0]       up_gap, down_gap;
    logic                                 up_ok, down_ok;

    // Handshakes.
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.duty  = duty_reg;

    // Configuration port: register index is address bit two.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == dds_pwm_pkg::CFG_IDX_DEBOUNCE)
                     ? dds_pwm_pkg::APB_DATA_W'(debounce_ms_reg)
                     : dds_pwm_pkg::APB_DATA_W'(update_interval_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            update_interval_reg <= dds_pwm_pkg::UPDATE_RESET;
            debounce_ms_reg     <= dds_pwm_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == dds_pwm_pkg::CFG_IDX_DEBOUNCE)
                debounce_ms_reg <= pwdata[dds_pwm_pkg::CFG_W-1:0];
            else
                update_interval_reg <= pwdata[dds_pwm_pkg::CFG_W-1:0];
        end
    end

    // Table addressing: write from the request, two reads from the phase.
    assign tbl_write = req_fire && (req.req_type == dds_pwm_pkg::REQ_WRITE);
    assign wr_idx    = dds_pwm_pkg::IDX_W'(req.table_index);
    assign rd_idx_a  = phase_reg[dds_pwm_pkg::PHASE_W-1 -: dds_pwm_pkg::IDX_W];
    assign rd_idx_c  = rd_idx_a + dds_pwm_pkg::IDX_W'(1);
    assign frac      = phase_reg[dds_pwm_pkg::FRAC_LSB +: dds_pwm_pkg::FRAC_W];

    always_ff @(posedge clk)
    begin
        if (tbl_write)
            wave_mem[wr_idx] <= req.table_data;
        rd_a_reg <= wave_mem[rd_idx_a];
        rd_c_reg <= wave_mem[rd_idx_c];
    end

    // Tuning word shifted by three bits per octave level.
    always_comb
    begin
        case (octave_level_reg)
            dds_pwm_pkg::OCT_DOWN2: octave_word = req.base_tuning >> (2 * dds_pwm_pkg::OCT_STEP);
            dds_pwm_pkg::OCT_DOWN1: octave_word = req.base_tuning >> dds_pwm_pkg::OCT_STEP;
            dds_pwm_pkg::OCT_UP1:   octave_word = req.base_tuning << dds_pwm_pkg::OCT_STEP;
            dds_pwm_pkg::OCT_UP2:   octave_word = req.base_tuning << (2 * dds_pwm_pkg::OCT_STEP);
            default:                octave_word = req.base_tuning;
        endcase
    end

    // Latch decision and debounce gaps (differences wrap modulo 2^32).
    assign tick_inc = tick_count_reg + dds_pwm_pkg::CFG_W'(1);
    assign latch    = first_tick_reg || (tick_inc >= update_interval_reg);
    assign up_gap   = req.time_ms - last_up_ms_reg;
    assign down_gap = req.time_ms - last_down_ms_reg;
    assign up_ok    = (up_gap > dds_pwm_pkg::TIME_W'(debounce_ms_reg))
                   && (octave_level_reg < dds_pwm_pkg::OCT_UP2);
    assign down_ok  = (down_gap > dds_pwm_pkg::TIME_W'(debounce_ms_reg))
                   && (octave_level_reg > dds_pwm_pkg::OCT_DOWN2);

    // Interpolation and scaling arithmetic, one stage per state.
    assign weight_a    = dds_pwm_pkg::FRAC_ONE - {1'b0, frac};
    assign prod_a_next = dds_pwm_pkg::PROD_W'(rd_a_reg) * dds_pwm_pkg::PROD_W'(weight_a);
    assign interp_sum  = prod_a_reg
                       + dds_pwm_pkg::PROD_W'(rd_c_reg) * dds_pwm_pkg::PROD_W'(frac);
    assign val_next    = dds_pwm_pkg::WAVE_W'(interp_sum >> dds_pwm_pkg::FRAC_W);
    assign mv_next     = dds_pwm_pkg::MV_W'(held_volume_reg) * dds_pwm_pkg::MV_W'(val_reg);
    // Times 800 as 512 + 256 + 32, then drop the 16 fraction bits.
    assign scaled      = (dds_pwm_pkg::SCALED_W'(mv_reg) << 9)
                       + (dds_pwm_pkg::SCALED_W'(mv_reg) << 8)
                       + (dds_pwm_pkg::SCALED_W'(mv_reg) << 5);
    assign m_next      = dds_pwm_pkg::M_W'(scaled >> dds_pwm_pkg::FRAC_W);

    // Divide by 4095: the quotient by 4096 is low by at most one, and the
    // remainder against 4095 is the low twelve bits plus that estimate.
    assign q_est = m_reg[dds_pwm_pkg::M_W-1:dds_pwm_pkg::DIV_SH];
    assign q_rem = dds_pwm_pkg::REM_W'(m_reg[dds_pwm_pkg::DIV_SH-1:0])
                 + dds_pwm_pkg::REM_W'(q_est);
    assign q_fix = q_est + dds_pwm_pkg::QE_W'(q_rem >= dds_pwm_pkg::WAVE_FULL);

    always_comb
    begin
        if (state_reg == S_PHASE)
            res_next = dds_pwm_pkg::DUTY_OFF;
        else if (m_reg >= dds_pwm_pkg::SAT_LIMIT)
            res_next = dds_pwm_pkg::DUTY_MAX;
        else
            res_next = dds_pwm_pkg::DUTY_MID + dds_pwm_pkg::DUTY_W'(q_fix);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MULA)
            prod_a_reg <= prod_a_next;
        if (state_reg == S_MULC)
            val_reg <= val_next;
        if (state_reg == S_VOL)
            mv_reg <= mv_next;
        if (state_reg == S_SCALE)
            m_reg <= m_next;
        if ((state_reg == S_DIV) || (state_reg == S_PHASE))
            res_reg <= res_next;
    end

    // Request sequencer and oscillator state update.
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        step_word_next    = step_word_reg;
        silent_pitch_next = silent_pitch_reg;
        held_volume_next  = held_volume_reg;
        tick_count_next   = tick_count_reg;
        first_tick_next   = first_tick_reg;
        octave_level_next = octave_level_reg;
        last_up_ms_next   = last_up_ms_reg;
        last_down_ms_next = last_down_ms_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        duty_next         = duty_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.req_type)
                        dds_pwm_pkg::REQ_UP:
                        begin
                            if (up_ok)
                            begin
                                octave_level_next = octave_level_reg + dds_pwm_pkg::OCT_W'(1);
                                last_up_ms_next   = req.time_ms;
                            end
                        end
                        dds_pwm_pkg::REQ_DOWN:
                        begin
                            if (down_ok)
                            begin
                                octave_level_next = octave_level_reg - dds_pwm_pkg::OCT_W'(1);
                                last_down_ms_next = req.time_ms;
                            end
                        end
                        dds_pwm_pkg::REQ_TICK:
                        begin
                            if (first_tick_reg)
                                first_tick_next = 1'b0;
                            else if (latch)
                                tick_count_next = '0;
                            else
                                tick_count_next = tick_inc;
                            if (latch)
                            begin
                                step_word_next    = octave_word;
                                silent_pitch_next = (req.base_tuning == '0);
                                held_volume_next  = req.volume;
                            end
                            state_next = S_PHASE;
                        end
                        default:
                        begin
                            // Table writes go straight to the memory.
                        end
                    endcase
                end
            end
            S_PHASE:
            begin
                if (silent_pitch_reg || (held_volume_reg == '0))
                    state_next = S_OUT;
                else
                begin
                    phase_next = phase_reg + step_word_reg;
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_MULA;
            S_MULA:  state_next = S_MULC;
            S_MULC:  state_next = S_VOL;
            S_VOL:   state_next = S_SCALE;
            S_SCALE: state_next = S_DIV;
            S_DIV:   state_next = S_OUT;
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    duty_next      = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= '0;
            step_word_reg    <= '0;
            silent_pitch_reg <= 1'b1;
            held_volume_reg  <= '0;
            tick_count_reg   <= '0;
            first_tick_reg   <= 1'b1;
            octave_level_reg <= dds_pwm_pkg::OCT_ZERO;
            last_up_ms_reg   <= '0;
            last_down_ms_reg <= '0;
            rsp_valid_reg    <= 1'b0;
            duty_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            step_word_reg    <= step_word_next;
            silent_pitch_reg <= silent_pitch_next;
            held_volume_reg  <= held_volume_next;
            tick_count_reg   <= tick_count_next;
            first_tick_reg   <= first_tick_next;
            octave_level_reg <= octave_level_next;
            last_up_ms_reg   <= last_up_ms_next;
            last_down_ms_reg <= last_down_ms_next;
            rsp_valid_reg    <= rsp_valid_next;
            duty_reg         <= duty_next;
        end
    end

endmodule

FILE: design/dds_pwm_chk.sv
// ============================================================================
// dds_pwm_chk
// Port-level checks of the PWM duty oscillator, bound to its top level.
// ============================================================================
module dds_pwm_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input dds_pwm_pkg::req_type_t              req_type,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic [dds_pwm_pkg::DUTY_W-1:0]      duty,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [dds_pwm_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [dds_pwm_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [dds_pwm_pkg::APB_DATA_W-1:0]  prdata
);

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(duty))
        else $error("result changed while stalled");

    // A duty is either silence or within the upper half of the PWM range.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (duty != '0) |-> (duty >= dds_pwm_pkg::DUTY_MID)
                                   && (duty <= dds_pwm_pkg::DUTY_MAX))
        else $error("duty out of range");

    // A sample tick keeps the block busy in the cycle after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == dds_pwm_pkg::REQ_TICK) |=> !req_ready)
        else $error("request taken while a sample tick is in progress");

    // A write to the update interval register reads back at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[2] == dds_pwm_pkg::CFG_IDX_UPDATE)
        |=> paddr[2] || (prdata[dds_pwm_pkg::CFG_W-1:0]
                         == $past(pwdata[dds_pwm_pkg::CFG_W-1:0])))
        else $error("update interval readback mismatch");

endmodule

bind dds_oscillator_pwm_duty_unit dds_pwm_chk u_dds_pwm_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .duty      (rsp.duty),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
